// ----- src/sha_pkg.sv -----
// sha-256 hasher shared types, constants and round functions
package sha_pkg;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [0:0] CMD_ABSORB = 1'b0;
  localparam logic [0:0] CMD_FINAL = 1'b1;

  typedef logic [31:0] word_t;

  typedef struct packed {
    word_t a, b, c, d, e, f, g, h;
  } hstate_t;

  localparam hstate_t INIT_HASH = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  function automatic word_t round_k(input logic [5:0] t);
    word_t k;
    unique case (t)
      6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic word_t ror(input word_t x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t sig0(input word_t x);
    return ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t sig1(input word_t x);
    return ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
  endfunction

  function automatic hstate_t round_step(input hstate_t v, input word_t k, input word_t w);
    word_t s1, ch, x, s0, mj;
    hstate_t r;
    s1 = ror(v.e, 6) ^ ror(v.e, 11) ^ ror(v.e, 25);
    ch = (v.e & v.f) ^ (~v.e & v.g);
    x = v.h + s1 + ch + k + w;
    s0 = ror(v.a, 2) ^ ror(v.a, 13) ^ ror(v.a, 22);
    mj = (v.a & v.b) ^ (v.a & v.c) ^ (v.b & v.c);
    r.h = v.g; r.g = v.f; r.f = v.e; r.e = v.d + x;
    r.d = v.c; r.c = v.b; r.b = v.a; r.a = x + s0 + mj;
    return r;
  endfunction

  function automatic hstate_t hadd(input hstate_t p, input hstate_t q);
    hstate_t r;
    r.a = p.a + q.a; r.b = p.b + q.b; r.c = p.c + q.c; r.d = p.d + q.d;
    r.e = p.e + q.e; r.f = p.f + q.f; r.g = p.g + q.g; r.h = p.h + q.h;
    return r;
  endfunction

  function automatic word_t hword(input hstate_t s, input logic [2:0] i);
    word_t r;
    unique case (i)
      3'd0: r = s.a; 3'd1: r = s.b; 3'd2: r = s.c; 3'd3: r = s.d;
      3'd4: r = s.e; 3'd5: r = s.f; 3'd6: r = s.g;
      default: r = s.h;
    endcase
    return r;
  endfunction

endpackage

// ----- src/sha256_stream_hasher.sv -----
// sha-256 streaming hasher top level: control, compression rounds, digest output
//
// channel | direction | fields
// in_     | input     | command, message_byte
// out_    | output    | digest_word, word_index, last_word
//
// an absorb writes one byte; the 64th byte of a block starts a compression of
// load, prefetch, round and update steps, input stalled
// a finalize pads each block, compresses one or two
// blocks, then sends eight words at one per cycle while out_stall is low
// rst_n is synchronous and restores the initial hash and an empty length
module sha256_stream_hasher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_command,
  input  logic [7:0]  in_message_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);
  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_PAD   = 7'b0000010,
    ST_LOAD  = 7'b0000100,
    ST_ROUND = 7'b0001000,
    ST_ADD   = 7'b0010000,
    ST_OUT   = 7'b0100000,
    ST_PRE   = 7'b1000000
  } state_t;

  state_t            state_r, state_nxt;
  sha_pkg::hstate_t  hash_r, work_r;
  logic [5:0]        fill_r;
  logic [63:0]       bits_r;
  logic [6:0]        cnt_r;
  logic              final_r;
  logic              second_r;
  logic [2:0]        oidx_r;

  logic              bw_en;
  logic [3:0]        bw_addr, bw_be, br_addr;
  sha_pkg::word_t    bw_data, br_data;
  logic              sw_en;
  logic [3:0]        sw_addr, sra, srb;
  sha_pkg::word_t    sw_data, srd_a, srd_b, w_cur;
  sha_pkg::word_t    w_hist [2];
  sha_pkg::word_t    w_m7, w_m16_r;

  logic accept_in;
  assign accept_in = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);

  sha_buf_mem u_buf (
    .clk(clk), .wr_en(bw_en), .wr_addr(bw_addr), .wr_be(bw_be),
    .wr_data(bw_data), .rd_addr(br_addr), .rd_data(br_data));

  sha_sched_mem u_sched (
    .clk(clk), .wr_en(sw_en), .wr_addr(sw_addr), .wr_data(sw_data),
    .rd_addr_a(sra), .rd_addr_b(srb), .rd_data_a(srd_a), .rd_data_b(srd_b));

  // pad word builder: pad word index is cnt_r[3:0]
  logic [3:0]  fw_idx;
  logic [1:0]  fb_idx;
  logic        long_pad;
  assign fw_idx   = fill_r[5:2];
  assign fb_idx   = fill_r[1:0];
  assign long_pad = (fill_r >= 6'd56);

  always_comb begin
    logic [3:0] pw;
    sha_pkg::word_t pad_w;
    logic [3:0] pad_be;
    pw = cnt_r[3:0];
    pad_w = '0;
    pad_be = 4'hf;
    if (!second_r && pw == fw_idx) begin
      pad_be = 4'h0;
      for (int b = 0; b < 4; b++) begin
        if (b[1:0] >= fb_idx) pad_be[3-b] = 1'b1;
        if (b[1:0] == fb_idx) pad_w[(3-b)*8 +: 8] = sha_pkg::PAD_BYTE;
      end
    end
    if ((second_r || !long_pad) && pw == 4'd14) pad_w = bits_r[63:32];
    if ((second_r || !long_pad) && pw == 4'd15) pad_w = bits_r[31:0];

    bw_en = 1'b0; bw_addr = fw_idx; bw_be = 4'h0; bw_data = '0;
    if (state_r == ST_IDLE && accept_in && in_command == sha_pkg::CMD_ABSORB) begin
      bw_en = 1'b1;
      bw_be = 4'b1000 >> fb_idx;
      bw_data = {4{in_message_byte}};
    end else if (state_r == ST_PAD) begin
      bw_addr = pw;
      bw_en = second_r || (pw >= fw_idx);
      bw_be = pad_be;
      bw_data = pad_w;
    end
  end

  // schedule: cnt_r is round index t; w[t] for t>=16 from ring
  logic [5:0] t;
  assign t = cnt_r[5:0];
  assign br_addr = cnt_r[3:0];
  assign sra = (state_r == ST_PRE) ? 4'd0 :
               (t < 6'd15) ? t[3:0] + 4'd1 : t[3:0] + 4'd2;
  assign srb = t[3:0] + 4'd10;
  assign w_m7 = srd_b;

  always_comb begin
    if (t < 6'd16) w_cur = srd_a;
    else w_cur = sha_pkg::sig1(w_hist[1]) + w_m7 + sha_pkg::sig0(srd_a) + w_m16_r;
  end

  always_comb begin
    sw_en = 1'b0; sw_addr = cnt_r[3:0] - 4'd1; sw_data = br_data;
    if (state_r == ST_LOAD && cnt_r != 7'd0) sw_en = 1'b1;
    else if (state_r == ST_ROUND && t >= 6'd16) begin
      sw_en = 1'b1; sw_addr = t[3:0]; sw_data = w_cur;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept_in) begin
          if (in_command == sha_pkg::CMD_FINAL) state_nxt = ST_PAD;
          else if (fill_r == 6'd63) state_nxt = ST_LOAD;
        end
      end
      ST_PAD:   if (cnt_r[3:0] == 4'd15) state_nxt = ST_LOAD;
      ST_LOAD:  if (cnt_r == 7'd16) state_nxt = ST_PRE;
      ST_PRE:   state_nxt = ST_ROUND;
      ST_ROUND: if (t == 6'd63) state_nxt = ST_ADD;
      ST_ADD: begin
        if (!final_r) state_nxt = ST_IDLE;
        else if (long_pad && !second_r) state_nxt = ST_PAD;
        else state_nxt = ST_OUT;
      end
      ST_OUT:   if (!out_stall && oidx_r == 3'd7) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE; hash_r <= sha_pkg::INIT_HASH; fill_r <= '0;
      bits_r <= '0; cnt_r <= '0; final_r <= 1'b0; second_r <= 1'b0; oidx_r <= '0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        ST_IDLE: begin
          cnt_r <= '0;
          if (accept_in) begin
            if (in_command == sha_pkg::CMD_FINAL) final_r <= 1'b1;
            else begin
              fill_r <= fill_r + 6'd1;
              bits_r <= bits_r + 64'd8;
            end
          end
        end
        ST_PAD:   cnt_r <= (cnt_r[3:0] == 4'd15) ? 7'd0 : cnt_r + 7'd1;
        ST_LOAD:  begin
          cnt_r <= (cnt_r == 7'd16) ? 7'd0 : cnt_r + 7'd1;
          work_r <= hash_r;
        end
        ST_PRE:   cnt_r <= '0;
        ST_ROUND: begin
          work_r <= sha_pkg::round_step(work_r, sha_pkg::round_k(t), w_cur);
          w_hist[1] <= w_hist[0];
          w_hist[0] <= w_cur;
          if (t == 6'd0) w_m16_r <= w_cur;
          else if (t >= 6'd16) w_m16_r <= srd_a;
          cnt_r <= cnt_r + 7'd1;
        end
        ST_ADD: begin
          hash_r <= sha_pkg::hadd(hash_r, work_r);
          cnt_r <= '0;
          if (final_r && long_pad && !second_r) second_r <= 1'b1;
          oidx_r <= '0;
        end
        ST_OUT: begin
          if (!out_stall) begin
            oidx_r <= oidx_r + 3'd1;
            if (oidx_r == 3'd7) begin
              hash_r <= sha_pkg::INIT_HASH; fill_r <= '0; bits_r <= '0;
              final_r <= 1'b0; second_r <= 1'b0;
            end
          end
        end
        default: cnt_r <= '0;
      endcase
    end
  end

  assign out_valid       = (state_r == ST_OUT);
  assign out_digest_word = sha_pkg::hword(hash_r, oidx_r);
  assign out_word_index  = oidx_r;
  assign out_last_word   = (oidx_r == 3'd7);

  a_out_only_in_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("output while input open");
  a_last_on_seven: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_word && !out_stall) |=> (state_r == ST_IDLE))
    else $error("digest did not end");
  a_round_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROUND) |-> (cnt_r < 7'd64)) else $error("round overrun");
endmodule

// ----- src/sha_buf_mem.sv -----
// 16-word block buffer memory with byte write enables and registered read
module sha_buf_mem (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [3:0]           wr_addr,
  input  logic [3:0]           wr_be,
  input  sha_pkg::word_t       wr_data,
  input  logic [3:0]           rd_addr,
  output sha_pkg::word_t       rd_data
);
  sha_pkg::word_t mem [16];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      for (int b = 0; b < 4; b++) begin
        if (wr_be[b]) mem[wr_addr][b*8 +: 8] <= wr_data[b*8 +: 8];
      end
    end
    rd_data <= mem[rd_addr];
  end
endmodule

// ----- src/sha_sched_mem.sv -----
// 16-word message schedule ring, one write and two registered reads
module sha_sched_mem (
  input  logic           clk,
  input  logic           wr_en,
  input  logic [3:0]     wr_addr,
  input  sha_pkg::word_t wr_data,
  input  logic [3:0]     rd_addr_a,
  input  logic [3:0]     rd_addr_b,
  output sha_pkg::word_t rd_data_a,
  output sha_pkg::word_t rd_data_b
);
  sha_pkg::word_t mem [16];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end
endmodule
